### sv/crc32_word_engine_defines.svh
// assertion macros shared by the crc32 word engine rtl
`ifndef CRC32_WORD_ENGINE_DEFINES_SVH
`define CRC32_WORD_ENGINE_DEFINES_SVH

// implication checked every clock outside reset
`define CRC32W_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked every clock outside reset
`define CRC32W_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define CRC32W_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/crc32w_pkg.sv
// shared types and constants of the crc32 word engine
package crc32w_pkg;

    localparam int unsigned CRC_W     = 32;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned ROW_W     = 5;

    typedef logic [CRC_W-1:0]              crc_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic [CRC_W-1:0][CRC_W-1:0]   crc_tbl_t;

    localparam crc_t INIT_RESET = 32'hFFFF_FFFF;
    localparam crc_t POLY_RESET = 32'h04C1_1DB7;

    // byte masks for short final words
    localparam crc_t MASK_1B = 32'h0000_00FF;
    localparam crc_t MASK_2B = 32'h0000_FFFF;
    localparam crc_t MASK_3B = 32'h00FF_FFFF;

    // byte count codes
    localparam cnt_t CNT_NONE = 3'd0;
    localparam cnt_t CNT_1B   = 3'd1;
    localparam cnt_t CNT_2B   = 3'd2;
    localparam cnt_t CNT_3B   = 3'd3;

    // configuration register indexes
    localparam cfg_idx_t REG_INIT_VALUE     = 8'd0;
    localparam cfg_idx_t REG_GENERATOR_POLY = 8'd1;

    // one msb-first shift of the crc register
    function automatic crc_t crc_shift(input crc_t v, input crc_t poly);
        crc_t r;
        r = {v[CRC_W-2:0], 1'b0};
        if (v[CRC_W-1]) begin
            r = r ^ poly;
        end
        return r;
    endfunction

endpackage

### sv/crc32w_table.sv
// builds the rows x^(32+k) mod p of the xor network, one row per cycle
module crc32w_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                poly_load,
    input  crc32w_pkg::crc_t    poly_data,
    output crc32w_pkg::crc_tbl_t tbl,
    output logic                busy
);

    crc32w_pkg::crc_t                    poly_reg;
    crc32w_pkg::crc_t                    row_val_reg;
    logic [crc32w_pkg::ROW_W-1:0]        row_reg;
    logic                                busy_reg;
    crc32w_pkg::crc_tbl_t                tbl_reg;

    // builder control: restart on reset or polynomial write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg    <= crc32w_pkg::POLY_RESET;
            row_val_reg <= crc32w_pkg::POLY_RESET;
            row_reg     <= '0;
            busy_reg    <= 1'b1;
        end else if (poly_load) begin
            poly_reg    <= poly_data;
            row_val_reg <= poly_data;
            row_reg     <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            row_val_reg <= crc32w_pkg::crc_shift(row_val_reg, poly_reg);
            row_reg     <= row_reg + 1'b1;
            if (row_reg == {crc32w_pkg::ROW_W{1'b1}}) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // row storage, one row written per build step
    always_ff @(posedge aclk) begin
        if (busy_reg && !poly_load) begin
            tbl_reg[row_reg] <= row_val_reg;
        end
    end

    assign tbl  = tbl_reg;
    assign busy = busy_reg;

endmodule

### sv/crc32w_datapath.sv
// input register, xor network and result register of the crc engine
module crc32w_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tbl_busy,
    input  crc32w_pkg::crc_tbl_t tbl,
    input  crc32w_pkg::crc_t     init_value,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  crc32w_pkg::crc_t     data_word,
    input  crc32w_pkg::cnt_t     byte_count,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output crc32w_pkg::crc_t     crc_out
);

    logic               hold_valid_reg;
    crc32w_pkg::crc_t   word_reg;
    logic               absorb_reg;
    logic               restart_reg;
    crc32w_pkg::crc_t   crc_reg;
    logic               out_valid_reg;
    crc32w_pkg::crc_t   out_data_reg;

    crc32w_pkg::crc_t   word_masked;
    crc32w_pkg::crc_t   crc_base;
    crc32w_pkg::crc_t   crc_mix;
    crc32w_pkg::crc_t   crc_net;
    crc32w_pkg::crc_t   crc_next;
    logic               out_free;
    logic               advance;
    logic               in_fire;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = hold_valid_reg && out_free;
    assign in_ready = !tbl_busy && (!hold_valid_reg || out_free);
    assign in_fire  = in_valid && in_ready;

    // keep only the valid low bytes of a short word
    always_comb begin
        case (byte_count)
            crc32w_pkg::CNT_1B: word_masked = data_word & crc32w_pkg::MASK_1B;
            crc32w_pkg::CNT_2B: word_masked = data_word & crc32w_pkg::MASK_2B;
            crc32w_pkg::CNT_3B: word_masked = data_word & crc32w_pkg::MASK_3B;
            default:            word_masked = data_word;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (in_fire) begin
            hold_valid_reg <= 1'b1;
        end else if (advance) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            word_reg    <= word_masked;
            absorb_reg  <= (byte_count != crc32w_pkg::CNT_NONE);
            restart_reg <= restart;
        end
    end

    // xor network: each set bit of the mixed word selects one table row
    assign crc_base = restart_reg ? init_value : crc_reg;
    assign crc_mix  = crc_base ^ word_reg;

    always_comb begin
        crc_net = '0;
        for (int k = 0; k < crc32w_pkg::CRC_W; k++) begin
            if (crc_mix[k]) begin
                crc_net = crc_net ^ tbl[k];
            end
        end
    end

    assign crc_next = absorb_reg ? crc_net : crc_base;

    // running crc and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= crc32w_pkg::INIT_RESET;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            crc_reg       <= crc_next;
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= crc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_out   = out_data_reg;

endmodule

### sv/crc32_word_engine.sv
// top level of the word-wide crc-32 engine (msb first, no reflection)
//
// usage:
//   s_ channel carries one 32-bit data word per transaction with its count of
//   valid low bytes (0..4, 5..7 act as 4) and a restart flag in s_tuser.
//   a restart loads init_value before the word; a zero count absorbs nothing.
//   m_ channel returns the running crc after every word, one per input.
//   cfg channel writes init_value (index 0) or generator_poly (index 1);
//   other indexes are ignored. write only while no word is in flight.
// timing:
//   m_tvalid rises after input acceptance once the word has passed the input
//   register, then the result register; the result is taken while m_tready is high.
//   one word per cycle is sustained while m_tready is high and no row build
//   runs, bounded by the 32-row xor network feeding crc_reg.
//   after reset and after each generator_poly write the row builder writes all
//   32 rows (one row per cycle) with s_tready low.
// stalls:
//   when m_tready is low the result register holds; one more word waits in
//   the input register, then s_tready drops until the result is taken.
`include "crc32_word_engine_defines.svh"

module crc32_word_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic [0:0]  s_tuser,   // [0] restart
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] crc_out
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    crc32w_pkg::crc_t     init_reg;
    crc32w_pkg::crc_tbl_t tbl;
    logic                 tbl_busy;
    logic                 cfg_fire;
    logic                 poly_load;
    logic                 init_load;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // register decode
    always_comb begin
        poly_load = 1'b0;
        init_load = 1'b0;
        unique case (cfg_index)
            crc32w_pkg::REG_INIT_VALUE:     init_load = cfg_fire;
            crc32w_pkg::REG_GENERATOR_POLY: poly_load = cfg_fire;
            default: begin
                poly_load = 1'b0;
                init_load = 1'b0;
            end
        endcase
    end

    // init value register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= crc32w_pkg::INIT_RESET;
        end else if (init_load) begin
            init_reg <= cfg_data;
        end
    end

    crc32w_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .poly_load (poly_load),
        .poly_data (cfg_data),
        .tbl       (tbl),
        .busy      (tbl_busy)
    );

    crc32w_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tbl_busy   (tbl_busy),
        .tbl        (tbl),
        .init_value (init_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_word  (s_tdata[31:0]),
        .byte_count (s_tdata[34:32]),
        .restart    (s_tuser[0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .crc_out    (m_tdata)
    );

    // no input accepted while the xor network rows are being rebuilt
    `CRC32W_ASSERT_IMP(a_no_accept_while_building, aclk, aresetn, tbl_busy, !s_tready, "input accepted during table build")
    // a polynomial write blocks input in the following cycle
    `CRC32W_ASSERT_NXT(a_poly_write_blocks, aclk, aresetn, poly_load, !s_tready, "input open right after polynomial write")
    // reset closes the input and clears m_tvalid while the table is rebuilt
    `CRC32W_ASSERT_NXT_ALL(a_reset_blocks, aclk, !aresetn, !s_tready && !m_tvalid, "channel active right after reset")

endmodule
